FILE: src/qmf_pkg.sv
// shared types, constants and coefficient functions of the qmf filter bank
`default_nettype none

package qmf_pkg;

	// field and arithmetic widths
	localparam int TAPS      = 20;
	localparam int LINE_LEN  = TAPS + 1;
	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 16;
	localparam int PROD_W    = SAMPLE_W + COEF_W;
	localparam int ACC_W     = 40;
	localparam int SUM_W     = ACC_W + 1;
	localparam int TAP_W     = $clog2(LINE_LEN);
	localparam int PROTO_FRAC  = 23;
	localparam int PROTO_SHIFT = PROTO_FRAC + 1 - COEF_W;

	// prototype lowpass filter in q1.23
	localparam int PROTO_Q23 [TAPS] = '{
		1346771, 3486625, 3851979, 1247514, -1378159,
		-1044555, 692263, 744550, -426155, -510413,
		295119, 334637, -214875, -204738, 156034,
		113647, -109728, -62491, 108502, -41904
	};

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_SUM,
		ST_ROUND
	} state_t;

	// control from the sequencer to the datapath
	typedef struct packed {
		logic             push;
		logic             walk;
		logic             clear;
		logic             sum;
		logic             load;
		logic [TAP_W-1:0] tap;
	} ctl_t;

	// prototype value rounded half up to coefficient width
	function automatic logic signed [COEF_W-1:0] proto_coef(input int idx);
		int v;
		v = PROTO_Q23[idx];
		return COEF_W'((v + (1 <<< (PROTO_SHIFT - 1))) >>> PROTO_SHIFT);
	endfunction

	// branch coefficient for tap k (k = 0 oldest entry)
	function automatic logic signed [COEF_W-1:0] tap_coef(input logic synth,
			input logic lower, input logic [TAP_W-1:0] k);
		logic [TAP_W-1:0]        rev;
		logic signed [COEF_W-1:0] c;
		rev = TAP_W'(TAPS - 1) - k;
		c = '0;
		if (k < TAP_W'(TAPS)) begin
			if (!synth) begin
				if (!lower) begin
					c = proto_coef(int'(rev));
				end else begin
					c = k[0] ? proto_coef(int'(k)) : -proto_coef(int'(k));
				end
			end else begin
				if (!lower) begin
					c = proto_coef(int'(k));
				end else begin
					c = k[0] ? -proto_coef(int'(rev)) : proto_coef(int'(rev));
				end
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: src/qmf_line.sv
// one delay line: push of two samples, then a full rotation to walk the taps
`default_nettype none

module qmf_line (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  qmf_pkg::ctl_t                         ctl,
	input  logic signed [qmf_pkg::SAMPLE_W-1:0]   push_a,
	input  logic signed [qmf_pkg::SAMPLE_W-1:0]   push_b,
	output logic signed [qmf_pkg::SAMPLE_W-1:0]   head
);
	import qmf_pkg::*;

	// entry 0 is the sample shifted out by the last push, entries 1..TAPS the line
	logic signed [SAMPLE_W-1:0] line_q [LINE_LEN];

	// push two samples or rotate one entry per walk cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINE_LEN; i++) begin
				line_q[i] <= '0;
			end
		end else if (ctl.push) begin
			for (int i = 0; i < LINE_LEN - 2; i++) begin
				line_q[i] <= line_q[i + 2];
			end
			line_q[LINE_LEN - 2] <= push_a;
			line_q[LINE_LEN - 1] <= push_b;
		end else if (ctl.walk) begin
			for (int i = 0; i < LINE_LEN - 1; i++) begin
				line_q[i] <= line_q[i + 1];
			end
			line_q[LINE_LEN - 1] <= line_q[0];
		end
	end

	assign head = line_q[0];

endmodule

`default_nettype wire

FILE: src/qmf_mac.sv
// two multiply-accumulate lanes over one delay line, one tap per cycle
`default_nettype none

module qmf_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  qmf_pkg::ctl_t                         ctl,
	input  logic                                  synth,
	input  logic                                  lower,
	input  logic signed [qmf_pkg::SAMPLE_W-1:0]   head,
	output logic signed [qmf_pkg::ACC_W-1:0]      acc_early,
	output logic signed [qmf_pkg::ACC_W-1:0]      acc_late
);
	import qmf_pkg::*;

	logic signed [COEF_W-1:0] coef_early;
	logic signed [COEF_W-1:0] coef_late;
	logic signed [PROD_W-1:0] prod_early_s1;
	logic signed [PROD_W-1:0] prod_late_s1;
	logic                     valid_s1;
	logic signed [ACC_W-1:0]  acc_early_q;
	logic signed [ACC_W-1:0]  acc_late_q;

	// early lane sees the line before the last push, late lane the line after
	always_comb begin
		coef_early = tap_coef(synth, lower, ctl.tap);
		coef_late  = '0;
		if (ctl.tap != '0) begin
			coef_late = tap_coef(synth, lower, ctl.tap - TAP_W'(1));
		end
	end

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.walk;
		end
	end

	always_ff @(posedge clk) begin
		prod_early_s1 <= coef_early * head;
		prod_late_s1  <= coef_late * head;
	end

	// accumulate stage
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_early_q <= '0;
			acc_late_q  <= '0;
		end else if (valid_s1) begin
			acc_early_q <= acc_early_q + {{(ACC_W-PROD_W){prod_early_s1[PROD_W-1]}},
				prod_early_s1};
			acc_late_q  <= acc_late_q + {{(ACC_W-PROD_W){prod_late_s1[PROD_W-1]}},
				prod_late_s1};
		end
	end

	assign acc_early = acc_early_q;
	assign acc_late  = acc_late_q;

endmodule

`default_nettype wire

FILE: src/qmf_ctrl.sv
// sequencer: accept, tap walk, pipeline drain, sum and output load
`default_nettype none

module qmf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          room,
	output logic          s_tready,
	output qmf_pkg::ctl_t ctl
);
	import qmf_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic [TAP_W-1:0] tap_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (tap_q == TAP_W'(LINE_LEN - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_SUM;
			ST_SUM:   state_d = ST_ROUND;
			ST_ROUND: begin
				if (room) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready  = 1'b0;
		ctl       = '0;
		ctl.tap   = tap_q;
		case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				ctl.push  = s_tvalid;
				ctl.clear = s_tvalid;
			end
			ST_WALK:  ctl.walk = 1'b1;
			ST_DRAIN: ctl.walk = 1'b0;
			ST_SUM:   ctl.sum  = 1'b1;
			ST_ROUND: ctl.load = room;
			default:  s_tready = 1'b0;
		endcase
	end

	// state and tap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_WALK) begin
				tap_q <= tap_q + TAP_W'(1);
			end else begin
				tap_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/qmf_round.sv
// branch sums, rounding, saturation and the output register
`default_nettype none

module qmf_round (
	input  logic                                clk,
	input  logic                                arst_n,
	input  qmf_pkg::ctl_t                       ctl,
	input  logic                                synth,
	input  logic signed [qmf_pkg::ACC_W-1:0]    acc_u_early,
	input  logic signed [qmf_pkg::ACC_W-1:0]    acc_u_late,
	input  logic signed [qmf_pkg::ACC_W-1:0]    acc_l_early,
	input  logic signed [qmf_pkg::ACC_W-1:0]    acc_l_late,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [2*qmf_pkg::SAMPLE_W-1:0]      m_tdata,
	output logic                                room
);
	import qmf_pkg::*;

	localparam int R_W = SUM_W + 1;
	localparam logic signed [R_W-1:0] SAT_HI = R_W'((2 ** (SAMPLE_W - 1)) - 1);
	localparam logic signed [R_W-1:0] SAT_LO = -SAT_HI - R_W'(1);

	logic signed [SUM_W-1:0]    sum_first_q;
	logic signed [SUM_W-1:0]    sum_second_q;
	logic signed [SAMPLE_W-1:0] sat_first;
	logic signed [SAMPLE_W-1:0] sat_second;
	logic                       m_tvalid_q;
	logic [2*SAMPLE_W-1:0]      m_tdata_q;

	// round half up by the mode's shift, then clamp to the sample range
	function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [SUM_W-1:0] v,
			input logic syn);
		logic signed [R_W-1:0] r;
		logic signed [R_W-1:0] q;
		if (syn) begin
			r = R_W'(v) + (R_W'(1) <<< (COEF_W - 3));
			q = r >>> (COEF_W - 2);
		end else begin
			r = R_W'(v) + (R_W'(1) <<< (COEF_W - 2));
			q = r >>> (COEF_W - 1);
		end
		if (q > SAT_HI) begin
			q = SAT_HI;
		end else if (q < SAT_LO) begin
			q = SAT_LO;
		end
		return q[SAMPLE_W-1:0];
	endfunction

	// branch sums: synthesis adds both lines, analysis takes each line alone
	always_ff @(posedge clk) begin
		if (ctl.sum) begin
			if (synth) begin
				sum_first_q  <= SUM_W'(acc_u_early) + SUM_W'(acc_l_early);
				sum_second_q <= SUM_W'(acc_u_late) + SUM_W'(acc_l_late);
			end else begin
				sum_first_q  <= SUM_W'(acc_u_late);
				sum_second_q <= SUM_W'(acc_l_late);
			end
		end
	end

	assign sat_first  = round_sat(sum_first_q, synth);
	assign sat_second = round_sat(sum_second_q, synth);

	// output register, held until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctl.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			m_tdata_q <= {sat_second, sat_first};
		end
	end

	assign room     = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

FILE: src/two_channel_qmf_filter_bank_top.sv
// two-channel qmf filter bank: analysis or synthesis of 20-tap branch pairs
//
// Input stream s_*: one transfer carries a sample pair (first sample in
// s_tdata[15:0], second in s_tdata[31:16], signed q1.15). Output stream m_*:
// one transfer per input pair with the two result samples packed the same way.
// cfg_we/cfg_wdata write the mode bit (0 analysis, 1 synthesis); write it only
// while no pair is in flight.
// Each pair is pushed into both delay lines in the cycle of its transfer; the
// lines then rotate one tap per cycle past two multiply-accumulate lanes each,
// followed by a product drain, branch summing and rounding into the output
// register. A new pair is taken only once the previous result has been loaded
// into the output register. While the output is drained, the input rate is
// set by the tap walk through the 21-entry delay lines.
// The output register is held while m_tready is low; the next pair is still
// accepted and processed, and waits before the output stage until the held
// result is taken.
// Reset clears both delay lines, the mode bit and all handshake state.
`default_nettype none

module two_channel_qmf_filter_bank_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,     // mode
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,       // sample_first [15:0], sample_second [31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata        // out_first [15:0], out_second [31:16]
);
	import qmf_pkg::*;

	logic                       mode_q;
	ctl_t                       ctl;
	logic                       room;
	logic signed [SAMPLE_W-1:0] sample_first;
	logic signed [SAMPLE_W-1:0] sample_second;
	logic signed [SAMPLE_W-1:0] upper_push_b;
	logic signed [SAMPLE_W-1:0] lower_push_a;
	logic signed [SAMPLE_W-1:0] upper_head;
	logic signed [SAMPLE_W-1:0] lower_head;
	logic signed [ACC_W-1:0]    acc_u_early;
	logic signed [ACC_W-1:0]    acc_u_late;
	logic signed [ACC_W-1:0]    acc_l_early;
	logic signed [ACC_W-1:0]    acc_l_late;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// push values: analysis feeds the pair to both lines, synthesis one sample and a zero
	assign sample_first  = s_tdata[SAMPLE_W-1:0];
	assign sample_second = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
	assign upper_push_b  = mode_q ? '0 : sample_second;
	assign lower_push_a  = mode_q ? sample_second : sample_first;

	qmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.room     (room),
		.s_tready (s_tready),
		.ctl      (ctl)
	);

	qmf_line u_upper_line (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.push_a (sample_first),
		.push_b (upper_push_b),
		.head   (upper_head)
	);

	qmf_line u_lower_line (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.push_a (lower_push_a),
		.push_b (upper_push_b),
		.head   (lower_head)
	);

	qmf_mac u_upper_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.synth     (mode_q),
		.lower     (1'b0),
		.head      (upper_head),
		.acc_early (acc_u_early),
		.acc_late  (acc_u_late)
	);

	qmf_mac u_lower_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.synth     (mode_q),
		.lower     (1'b1),
		.head      (lower_head),
		.acc_early (acc_l_early),
		.acc_late  (acc_l_late)
	);

	qmf_round u_round (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.synth       (mode_q),
		.acc_u_early (acc_u_early),
		.acc_u_late  (acc_u_late),
		.acc_l_early (acc_l_early),
		.acc_l_late  (acc_l_late),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.m_tdata     (m_tdata),
		.room        (room)
	);

endmodule

`default_nettype wire

FILE: src/qmf_checker.sv
// port-level checks of the qmf filter bank, bound to the top level
`default_nettype none

module qmf_port_assert (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output changed");

	// after an input transfer the block is busy through the tap walk
	a_busy_walk: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##20 !s_tready)
		else $error("input taken during tap walk");

	// a new result is only loaded from the busy phase
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("output appeared without a processed pair");

	// reset held over an edge empties the output and opens the input
	a_reset: assert property (@(posedge clk)
		!arst_n ##1 !arst_n |-> !m_tvalid && s_tready)
		else $error("reset state wrong");

endmodule

bind two_channel_qmf_filter_bank_top qmf_port_assert u_qmf_port_assert (.*);

`default_nettype wire
